[rtl/core/bpa_pkg.sv]
// Package: types, constants and helper functions for the bitmap page allocator.
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

  localparam int unsigned MAP_PAGES = 4096;
  localparam int unsigned PAGE_W    = $clog2(MAP_PAGES);
  localparam int unsigned CNT_W     = PAGE_W + 1;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned WIDX_W    = $clog2(WORD_W);
  localparam int unsigned NUM_ROWS  = MAP_PAGES / WORD_W;
  localparam int unsigned ROW_W     = $clog2(NUM_ROWS);
  localparam int unsigned LIMIT_RST = 4096;

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_FREE    = 3'd1,
    CMD_LOCK    = 3'd2,
    CMD_RESERVE = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RUN_RD,
    ST_RUN_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [PAGE_W-1:0] page_number;
    logic [CNT_W-1:0]  run_len;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [PAGE_W-1:0] alloc_page;
    logic [CNT_W-1:0]  free_pages;
    logic [CNT_W-1:0]  used_pages;
    logic [CNT_W-1:0]  reserved_pages;
  } out_item_t;

  typedef struct packed {
    logic              rd_en;
    logic [ROW_W-1:0]  rd_addr;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              clr;
  } map_req_t;

  // Pages of row that fall in [lo, hi); hi must be at least 1.
  function automatic logic [WORD_W-1:0] span_mask(logic [ROW_W-1:0] row,
                                                   logic [PAGE_W-1:0] lo,
                                                   logic [CNT_W-1:0] hi);
    logic [CNT_W-1:0]  last;
    logic [WORD_W-1:0] m;
    last = hi - CNT_W'(1);
    m    = '1;
    if (row == lo[PAGE_W-1:WIDX_W]) begin
      m = m & ({WORD_W{1'b1}} << lo[WIDX_W-1:0]);
    end
    if (row == last[PAGE_W-1:WIDX_W]) begin
      m = m & ({WORD_W{1'b1}} >> (WIDX_W'(WORD_W - 1) - last[WIDX_W-1:0]));
    end
    return m;
  endfunction

  function automatic logic [WIDX_W-1:0] low_idx(logic [WORD_W-1:0] v);
    logic [WIDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = WIDX_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [WIDX_W:0] pop_cnt(logic [WORD_W-1:0] v);
    logic [WIDX_W:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      n = n + (WIDX_W + 1)'(v[i]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[rtl/core/bpa_map_ram.sv]
// Page bitmap memory: one word per row, registered read, per-row valid bits.
`timescale 1ns / 1ps
`default_nettype none

module bpa_map_ram
  import bpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  map_req_t          req_i,
  output logic [WORD_W-1:0] rd_data_o
);

  logic [WORD_W-1:0]   mem_q [NUM_ROWS];
  logic [WORD_W-1:0]   rd_word_q;
  logic [NUM_ROWS-1:0] row_vld_q;
  logic                rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_word_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (req_i.clr) begin
        row_vld_q <= '0;
      end else if (req_i.wr_en) begin
        row_vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= row_vld_q[req_i.rd_addr];
      end
    end
  end

  // rows never written since reset or clear read as all free
  assign rd_data_o = rd_vld_q ? rd_word_q : '0;

endmodule

`default_nettype wire

[rtl/core/bpa_ctrl.sv]
// Command sequencer: allocation scan, run updates, counters and search hint.
`timescale 1ns / 1ps
`default_nettype none

module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  input  logic [CNT_W-1:0]  limit_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output out_item_t         res_data_o,
  output map_req_t          map_req_o,
  input  logic [WORD_W-1:0] map_rd_i
);

  state_e            state_q, state_d;
  cmd_e              cmd_q, cmd_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [PAGE_W-1:0] lo_q, lo_d;
  logic [CNT_W-1:0]  hi_q, hi_d;
  logic [PAGE_W-1:0] hint_q, hint_d;
  logic [CNT_W-1:0]  free_q, free_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [CNT_W-1:0]  rsv_q, rsv_d;
  logic              found_q, found_d;
  logic [PAGE_W-1:0] grant_q, grant_d;
  logic [WIDX_W:0]   chg_q, chg_d;
  logic              pend_q, pend_d;

  logic [CNT_W-1:0]  lim;
  logic [CNT_W:0]    run_sum;
  logic [CNT_W-1:0]  run_end;
  logic              run_empty;
  logic              alloc_empty;
  logic [CNT_W-1:0]  last_pg;
  logic              is_last;
  logic [WORD_W-1:0] span;
  logic [WORD_W-1:0] cand;
  logic              hit;
  logic [PAGE_W-1:0] hit_page;
  logic [CNT_W-1:0]  chg_n;
  logic              is_free;

  assign lim         = (limit_i > CNT_W'(MAP_PAGES)) ? CNT_W'(MAP_PAGES) : limit_i;
  assign run_sum     = {2'b0, in_data_i.page_number} + {1'b0, in_data_i.run_len};
  assign run_end     = (run_sum < {1'b0, lim}) ? run_sum[CNT_W-1:0] : lim;
  assign run_empty   = run_end <= {1'b0, in_data_i.page_number};
  assign alloc_empty = {1'b0, hint_q} >= lim;

  assign last_pg  = hi_q - CNT_W'(1);
  assign is_last  = row_q == last_pg[PAGE_W-1:WIDX_W];
  assign span     = span_mask(row_q, lo_q, hi_q);
  assign cand     = ~map_rd_i & span;
  assign hit      = |cand;
  assign hit_page = {row_q, low_idx(cand)};
  assign chg_n    = CNT_W'(chg_q);
  assign is_free  = cmd_q == CMD_FREE;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.cmd)
            CMD_ALLOC:   state_d = alloc_empty ? ST_DONE : ST_SCAN;
            CMD_FREE,
            CMD_LOCK,
            CMD_RESERVE: state_d = run_empty ? ST_DONE : ST_RUN_WR;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN:   state_d = (hit || is_last) ? ST_DONE : ST_SCAN;
      ST_RUN_RD: state_d = ST_RUN_WR;
      ST_RUN_WR: state_d = is_last ? ST_DONE : ST_RUN_RD;
      ST_DONE:   state_d = (!pend_q && res_ready_i) ? ST_IDLE : ST_DONE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_d   = cmd_q;
    row_d   = row_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    hint_d  = hint_q;
    free_d  = free_q;
    used_d  = used_q;
    rsv_d   = rsv_q;
    found_d = found_q;
    grant_d = grant_q;
    chg_d   = chg_q;
    pend_d  = 1'b0;

    map_req_o         = '0;
    map_req_o.rd_addr = row_q + ROW_W'(1);
    map_req_o.wr_addr = row_q;

    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    // counter update for the word written in the previous cycle
    if (pend_q) begin
      case (cmd_q)
        CMD_FREE: begin
          free_d = free_q + chg_n;
          used_d = (used_q > chg_n) ? used_q - chg_n : '0;
        end
        CMD_LOCK: begin
          free_d = (free_q > chg_n) ? free_q - chg_n : '0;
          used_d = used_q + chg_n;
        end
        default: begin
          free_d = (free_q > chg_n) ? free_q - chg_n : '0;
          rsv_d  = rsv_q + chg_n;
        end
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d   = in_data_i.cmd;
          found_d = 1'b1;
          grant_d = '0;
          case (in_data_i.cmd)
            CMD_ALLOC: begin
              found_d           = 1'b0;
              lo_d              = hint_q;
              hi_d              = lim;
              row_d             = hint_q[PAGE_W-1:WIDX_W];
              map_req_o.rd_addr = hint_q[PAGE_W-1:WIDX_W];
              map_req_o.rd_en   = !alloc_empty;
            end
            CMD_FREE,
            CMD_LOCK,
            CMD_RESERVE: begin
              lo_d              = in_data_i.page_number;
              hi_d              = run_end;
              row_d             = in_data_i.page_number[PAGE_W-1:WIDX_W];
              map_req_o.rd_addr = in_data_i.page_number[PAGE_W-1:WIDX_W];
              map_req_o.rd_en   = !run_empty;
            end
            CMD_CLEAR: begin
              map_req_o.clr = 1'b1;
              hint_d        = '0;
              free_d        = CNT_W'(MAP_PAGES);
              used_d        = '0;
              rsv_d         = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          map_req_o.wr_en   = 1'b1;
          map_req_o.wr_data = map_rd_i | (WORD_W'(1) << hit_page[WIDX_W-1:0]);
          found_d           = 1'b1;
          grant_d           = hit_page;
          hint_d            = hit_page;
          free_d            = (free_q != '0) ? free_q - CNT_W'(1) : '0;
          used_d            = used_q + CNT_W'(1);
        end else if (!is_last) begin
          map_req_o.rd_en = 1'b1;
          row_d           = row_q + ROW_W'(1);
        end
      end
      ST_RUN_RD: begin
        map_req_o.rd_en = 1'b1;
        row_d           = row_q + ROW_W'(1);
      end
      ST_RUN_WR: begin
        map_req_o.wr_en   = 1'b1;
        map_req_o.wr_data = is_free ? (map_rd_i & ~span) : (map_rd_i | span);
        chg_d             = pop_cnt(is_free ? (map_rd_i & span) : (~map_rd_i & span));
        pend_d            = 1'b1;
      end
      ST_DONE: begin
        res_valid_o = !pend_q;
      end
      default: ;
    endcase
  end

  assign res_data_o.found          = found_q;
  assign res_data_o.alloc_page     = grant_q;
  assign res_data_o.free_pages     = free_q;
  assign res_data_o.used_pages     = used_q;
  assign res_data_o.reserved_pages = rsv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hint_q  <= '0;
      free_q  <= CNT_W'(MAP_PAGES);
      used_q  <= '0;
      rsv_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      hint_q  <= hint_d;
      free_q  <= free_d;
      used_q  <= used_d;
      rsv_q   <= rsv_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    row_q   <= row_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    found_q <= found_d;
    grant_q <= grant_d;
    chg_q   <= chg_d;
  end

endmodule

`default_nettype wire

[rtl/core/bitmap_page_allocator.sv]
// Bitmap page allocator top level: limit register, output register, sequencer and map memory.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one command word:
//   allocate, free run, lock run, reserve run or clear all. Each command
//   gives exactly one result word on out_valid_o/out_ready_i/out_data_o with
//   the grant (allocate only) and the free, used and reserved page counts.
//   The page map is kept as 32-page rows in a memory with a registered read.
//   Allocate reads one row per cycle from the hint row up to the limit row.
//   Runs read, then write back, each row touched; clear and unknown
//   commands go straight to the result. One command is worked on at a time.
//   cfg_we_i/cfg_wdata_i write the page limit; write it only while the block
//   is idle. Reset sets the limit to 4096, frees every page (per-row valid
//   bits, no clearing pass), sets the free count to 4096 and zeroes the hint
//   and the used and reserved counts.
//   The result sits in an output register; a new command is taken while it
//   waits, but its own result holds until out_ready_i frees the register.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_allocator
  import bpa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i
);

  logic [CNT_W-1:0]  limit_q;
  logic              out_valid_q;
  out_item_t         out_data_q;
  logic              res_valid;
  logic              res_ready;
  out_item_t         res_data;
  map_req_t          map_req;
  logic [WORD_W-1:0] map_rd;

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= CNT_W'(LIMIT_RST);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (res_valid && res_ready) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  bpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .limit_i     (limit_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .map_req_o   (map_req),
    .map_rd_i    (map_rd)
  );

  bpa_map_ram u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (map_req),
    .rd_data_o (map_rd)
  );

endmodule

`default_nettype wire
